// ===== rtl/core/pcl_pkg.sv =====
// Shared types, constants and helper functions of the polyline rectangle clipper.
package pcl_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int INT_W           = 64;
    localparam int PROD_W          = 2 * INT_W;
    localparam int PART_W          = INT_W / 2;
    localparam int QSAT_LOG        = 52;
    localparam int DIV_STEPS       = QSAT_LOG + 1;
    localparam int STEP_W          = $clog2(DIV_STEPS + 1);
    localparam int MAX_MOVES       = 16;
    localparam int MOVE_W          = $clog2(MAX_MOVES + 1);
    localparam int NUM_REGS        = 4;
    localparam int REG_IDX_W       = $clog2(NUM_REGS);

    typedef logic [3:0] ocode_t;

    localparam ocode_t OC_LEFT   = 4'd1;
    localparam ocode_t OC_RIGHT  = 4'd2;
    localparam ocode_t OC_BOTTOM = 4'd4;
    localparam ocode_t OC_TOP    = 4'd8;

    localparam logic [REG_IDX_W-1:0] REG_XMIN = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_XMAX = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_YMIN = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_YMAX = 2'd3;

    typedef enum logic [1:0] {
        EDGE_TOP,
        EDGE_BOTTOM,
        EDGE_RIGHT,
        EDGE_LEFT
    } clip_edge_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TEST,
        ST_SETUP,
        ST_DIVGO,
        ST_DIVWAIT,
        ST_WB,
        ST_OUT0,
        ST_OUT1
    } ctrl_state_t;

    typedef enum logic [2:0] {
        MD_IDLE,
        MD_MUL,
        MD_CHK,
        MD_DIV,
        MD_DONE
    } md_state_t;

    typedef struct packed {
        logic take;
        logic seg_accept;
        logic seg_reject;
        logic setup;
        logic div_start;
        logic writeback;
        logic put0;
        logic put1;
    } ctrl_cmd_t;

    typedef struct packed {
        logic in_valid;
        logic first;
        logic accept;
        logic reject;
        logic emit0;
        logic emit1;
        logic pend1;
        logic dt_zero;
        logic div_done;
        logic out_free;
    } dp_sts_t;

    function automatic ocode_t outcode(
        input logic signed [INT_W-1:0] x,
        input logic signed [INT_W-1:0] y,
        input logic signed [INT_W-1:0] xmin,
        input logic signed [INT_W-1:0] xmax,
        input logic signed [INT_W-1:0] ymin,
        input logic signed [INT_W-1:0] ymax
    );
        ocode_t c;
        c = '0;
        if (x < xmin)
        begin
            c = c | OC_LEFT;
        end
        else if (x > xmax)
        begin
            c = c | OC_RIGHT;
        end
        if (y < ymin)
        begin
            c = c | OC_BOTTOM;
        end
        else if (y > ymax)
        begin
            c = c | OC_TOP;
        end
        return c;
    endfunction

endpackage

// ===== rtl/core/pcl_vtx_if.sv =====
// Input vertex channel of the polyline rectangle clipper.
interface pcl_vtx_if import pcl_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) ();
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] vertex_x;
    logic signed [COORD_WIDTH-1:0] vertex_y;
    logic                          starts_line;

    modport source (output valid, output vertex_x, output vertex_y, output starts_line,
                    input ready);
    modport sink (input valid, input vertex_x, input vertex_y, input starts_line,
                  output ready);
endinterface

// ===== rtl/core/pcl_res_if.sv =====
// Output vertex channel of the polyline rectangle clipper.
interface pcl_res_if import pcl_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) ();
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] out_x;
    logic signed [COORD_WIDTH-1:0] out_y;
    logic                          starts_part;
    logic                          last_of_run;

    modport source (output valid, output out_x, output out_y, output starts_part,
                    output last_of_run, input ready);
    modport sink (input valid, input out_x, input out_y, input starts_part,
                  input last_of_run, output ready);
endinterface

// ===== rtl/core/pcl_muldiv.sv =====
// Shared multiply then divide unit: floor(a*b/d) with saturation, one quotient bit per cycle.
module pcl_muldiv import pcl_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [INT_W-1:0] a,
    input  logic [INT_W-1:0] b,
    input  logic [INT_W-1:0] d,
    output logic             done,
    output logic [INT_W-1:0] q
);
    localparam int HI_W = PROD_W - DIV_STEPS;
    localparam logic [DIV_STEPS-1:0] QSAT_Q = DIV_STEPS'(1) << QSAT_LOG;

    md_state_t state_reg, state_next;
    logic [INT_W-1:0]     a_reg, b_reg, d_reg, rem_reg;
    logic [PROD_W-1:0]    acc_reg;
    logic [DIV_STEPS-1:0] low_reg, q_reg;
    logic                 sat_reg;
    logic [STEP_W-1:0]    step_reg;

    logic [1:0]           k;
    logic [PART_W-1:0]    a_part, b_part;
    logic [INT_W-1:0]     prod;
    logic [PROD_W-1:0]    prod_shifted;
    logic [HI_W-1:0]      acc_hi;
    logic                 over;
    logic [INT_W:0]       trial, diff;
    logic                 ge;

    assign k            = step_reg[1:0];
    assign a_part       = k[0] ? a_reg[INT_W-1:PART_W] : a_reg[PART_W-1:0];
    assign b_part       = k[1] ? b_reg[INT_W-1:PART_W] : b_reg[PART_W-1:0];
    assign prod         = a_part * b_part;
    assign prod_shifted = PROD_W'(prod) << (PART_W * (32'(k[0]) + 32'(k[1])));
    assign acc_hi       = acc_reg[PROD_W-1:DIV_STEPS];
    assign over         = acc_hi >= HI_W'(d_reg);
    assign trial        = {rem_reg, low_reg[DIV_STEPS-1]};
    assign ge           = trial >= {1'b0, d_reg};
    assign diff         = trial - {1'b0, d_reg};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            MD_IDLE:
            begin
                if (start)
                begin
                    state_next = MD_MUL;
                end
            end
            MD_MUL:
            begin
                if (k == 2'd3)
                begin
                    state_next = MD_CHK;
                end
            end
            MD_CHK:
            begin
                state_next = over ? MD_DONE : MD_DIV;
            end
            MD_DIV:
            begin
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    state_next = MD_DONE;
                end
            end
            MD_DONE:
            begin
                state_next = MD_IDLE;
            end
            default:
            begin
                state_next = MD_IDLE;
            end
        endcase
    end

    always_comb
    begin
        done = (state_reg == MD_DONE);
        q    = INT_W'((sat_reg || (q_reg > QSAT_Q)) ? QSAT_Q : q_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MD_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            MD_IDLE:
            begin
                if (start)
                begin
                    a_reg    <= a;
                    b_reg    <= b;
                    d_reg    <= d;
                    acc_reg  <= '0;
                    step_reg <= '0;
                end
            end
            MD_MUL:
            begin
                acc_reg  <= acc_reg + prod_shifted;
                step_reg <= step_reg + STEP_W'(1);
            end
            MD_CHK:
            begin
                sat_reg  <= over;
                rem_reg  <= acc_hi[INT_W-1:0];
                low_reg  <= acc_reg[DIV_STEPS-1:0];
                q_reg    <= '0;
                step_reg <= '0;
            end
            MD_DIV:
            begin
                rem_reg  <= ge ? diff[INT_W-1:0] : trial[INT_W-1:0];
                q_reg    <= {q_reg[DIV_STEPS-2:0], ge};
                low_reg  <= {low_reg[DIV_STEPS-2:0], 1'b0};
                step_reg <= step_reg + STEP_W'(1);
            end
            default:
            begin
            end
        endcase
    end

    a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (q <= INT_W'(QSAT_Q)))
        else $error("quotient above saturation bound");

    a_start_mul: assert property (@(posedge clk) disable iff (!rst_n)
        (start && state_reg == MD_IDLE) |=> (state_reg == MD_MUL))
        else $error("divider did not start multiplying");
endmodule

// ===== rtl/core/pcl_dpath.sv =====
// Datapath: segment endpoints, outcodes, interpolation operands, stitching and output word.
module pcl_dpath import pcl_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    pcl_vtx_if.sink                       vertex,
    pcl_res_if.source                     result,
    input  logic signed [COORD_WIDTH-1:0] clip_xmin,
    input  logic signed [COORD_WIDTH-1:0] clip_xmax,
    input  logic signed [COORD_WIDTH-1:0] clip_ymin,
    input  logic signed [COORD_WIDTH-1:0] clip_ymax,
    input  ctrl_cmd_t                     cmd,
    output dp_sts_t                       sts
);
    localparam int EXT_W = INT_W - COORD_WIDTH;

    logic signed [INT_W-1:0] p0x_reg, p0y_reg, p1x_reg, p1y_reg;
    logic signed [INT_W-1:0] tail_x_reg, tail_y_reg;
    logic signed [COORD_WIDTH-1:0] prev_x_reg, prev_y_reg;
    logic                    have_prev_reg, part_open_reg, emit1_reg;
    logic [MOVE_W-1:0]       n_reg;
    clip_edge_t              edge_sel_reg, edge_sel_next;
    logic                    side_reg;
    logic signed [INT_W-1:0] dt_reg, num_reg, dob_reg, ao_reg, bound_reg;
    logic                    dt_zero_reg, neg_reg;
    logic                    out_valid_reg, out_sp_reg, out_last_reg;
    logic signed [COORD_WIDTH-1:0] out_x_reg, out_y_reg;

    logic signed [INT_W-1:0] xmin_e, xmax_e, ymin_e, ymax_e, in_x_e, in_y_e;
    logic signed [INT_W-1:0] prev_x_e, prev_y_e;
    ocode_t                  c0, c1, co;
    logic                    load, first, emit0, emit1;
    logic signed [INT_W-1:0] a_t, a_o, b_t, b_o, bound;
    logic [INT_W-1:0]        mag_num, mag_dob, mag_dt, q;
    logic                    neg_c, div_done;
    logic signed [INT_W-1:0] new_o, nx, ny;

    assign xmin_e   = {{EXT_W{clip_xmin[COORD_WIDTH-1]}}, clip_xmin};
    assign xmax_e   = {{EXT_W{clip_xmax[COORD_WIDTH-1]}}, clip_xmax};
    assign ymin_e   = {{EXT_W{clip_ymin[COORD_WIDTH-1]}}, clip_ymin};
    assign ymax_e   = {{EXT_W{clip_ymax[COORD_WIDTH-1]}}, clip_ymax};
    assign in_x_e   = {{EXT_W{vertex.vertex_x[COORD_WIDTH-1]}}, vertex.vertex_x};
    assign in_y_e   = {{EXT_W{vertex.vertex_y[COORD_WIDTH-1]}}, vertex.vertex_y};
    assign prev_x_e = {{EXT_W{prev_x_reg[COORD_WIDTH-1]}}, prev_x_reg};
    assign prev_y_e = {{EXT_W{prev_y_reg[COORD_WIDTH-1]}}, prev_y_reg};

    assign c0 = outcode(p0x_reg, p0y_reg, xmin_e, xmax_e, ymin_e, ymax_e);
    assign c1 = outcode(p1x_reg, p1y_reg, xmin_e, xmax_e, ymin_e, ymax_e);
    assign co = (c0 != '0) ? c0 : c1;

    assign vertex.ready = cmd.take;
    assign load         = vertex.valid && cmd.take;
    assign first        = vertex.starts_line || !have_prev_reg;

    assign emit0 = !part_open_reg || (tail_x_reg != p0x_reg) || (tail_y_reg != p0y_reg);
    assign emit1 = !part_open_reg ||
                   (emit0 ? ((p0x_reg != p1x_reg) || (p0y_reg != p1y_reg))
                          : ((tail_x_reg != p1x_reg) || (tail_y_reg != p1y_reg)));

    always_comb
    begin
        if ((co & OC_TOP) != '0)
        begin
            edge_sel_next = EDGE_TOP;
        end
        else if ((co & OC_BOTTOM) != '0)
        begin
            edge_sel_next = EDGE_BOTTOM;
        end
        else if ((co & OC_RIGHT) != '0)
        begin
            edge_sel_next = EDGE_RIGHT;
        end
        else
        begin
            edge_sel_next = EDGE_LEFT;
        end
        case (edge_sel_next)
            EDGE_TOP, EDGE_BOTTOM:
            begin
                a_t   = p0y_reg;
                a_o   = p0x_reg;
                b_t   = p1y_reg;
                b_o   = p1x_reg;
                bound = (edge_sel_next == EDGE_TOP) ? ymax_e : ymin_e;
            end
            default:
            begin
                a_t   = p0x_reg;
                a_o   = p0y_reg;
                b_t   = p1x_reg;
                b_o   = p1y_reg;
                bound = (edge_sel_next == EDGE_RIGHT) ? xmax_e : xmin_e;
            end
        endcase
    end

    assign mag_num = num_reg[INT_W-1] ? -num_reg : num_reg;
    assign mag_dob = dob_reg[INT_W-1] ? -dob_reg : dob_reg;
    assign mag_dt  = dt_reg[INT_W-1] ? -dt_reg : dt_reg;
    assign neg_c   = (num_reg[INT_W-1] ^ dob_reg[INT_W-1] ^ dt_reg[INT_W-1]) &&
                     (num_reg != '0) && (dob_reg != '0);

    pcl_muldiv u_muldiv (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .a     (mag_num),
        .b     (mag_dob),
        .d     (mag_dt),
        .done  (div_done),
        .q     (q)
    );

    always_comb
    begin
        if (dt_zero_reg)
        begin
            new_o = ao_reg;
        end
        else if (neg_reg)
        begin
            new_o = ao_reg - q;
        end
        else
        begin
            new_o = ao_reg + q;
        end
        if (edge_sel_reg == EDGE_TOP || edge_sel_reg == EDGE_BOTTOM)
        begin
            nx = new_o;
            ny = bound_reg;
        end
        else
        begin
            nx = bound_reg;
            ny = new_o;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_prev_reg <= 1'b0;
            part_open_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            tail_x_reg    <= '0;
            tail_y_reg    <= '0;
            n_reg         <= '0;
        end
        else
        begin
            if (load)
            begin
                prev_x_reg    <= vertex.vertex_x;
                prev_y_reg    <= vertex.vertex_y;
                have_prev_reg <= 1'b1;
                n_reg         <= '0;
                if (first)
                begin
                    part_open_reg <= 1'b0;
                end
            end
            if (cmd.seg_reject)
            begin
                part_open_reg <= 1'b0;
            end
            if (cmd.seg_accept)
            begin
                part_open_reg <= 1'b1;
            end
            if (cmd.writeback)
            begin
                n_reg <= n_reg + MOVE_W'(1);
            end
            if (cmd.put0)
            begin
                tail_x_reg <= p0x_reg;
                tail_y_reg <= p0y_reg;
            end
            else if (cmd.put1)
            begin
                tail_x_reg <= p1x_reg;
                tail_y_reg <= p1y_reg;
            end
            if (cmd.put0 || cmd.put1)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            p0x_reg <= prev_x_e;
            p0y_reg <= prev_y_e;
            p1x_reg <= in_x_e;
            p1y_reg <= in_y_e;
        end
        if (cmd.seg_accept)
        begin
            emit1_reg <= emit1;
        end
        if (cmd.setup)
        begin
            edge_sel_reg <= edge_sel_next;
            side_reg     <= (c0 == '0);
            dt_reg       <= b_t - a_t;
            num_reg      <= bound - a_t;
            dob_reg      <= b_o - a_o;
            ao_reg       <= a_o;
            bound_reg    <= bound;
            dt_zero_reg  <= (b_t == a_t);
        end
        if (cmd.div_start)
        begin
            neg_reg <= neg_c;
        end
        if (cmd.writeback)
        begin
            if (side_reg)
            begin
                p1x_reg <= nx;
                p1y_reg <= ny;
            end
            else
            begin
                p0x_reg <= nx;
                p0y_reg <= ny;
            end
        end
        if (cmd.put0)
        begin
            out_x_reg    <= p0x_reg[COORD_WIDTH-1:0];
            out_y_reg    <= p0y_reg[COORD_WIDTH-1:0];
            out_sp_reg   <= 1'b1;
            out_last_reg <= !emit1_reg;
        end
        else if (cmd.put1)
        begin
            out_x_reg    <= p1x_reg[COORD_WIDTH-1:0];
            out_y_reg    <= p1y_reg[COORD_WIDTH-1:0];
            out_sp_reg   <= 1'b0;
            out_last_reg <= 1'b1;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.out_x       = out_x_reg;
    assign result.out_y       = out_y_reg;
    assign result.starts_part = out_sp_reg;
    assign result.last_of_run = out_last_reg;

    always_comb
    begin
        sts.in_valid = vertex.valid;
        sts.first    = first;
        sts.accept   = ((c0 | c1) == '0);
        sts.reject   = ((c0 | c1) != '0) &&
                       (((c0 & c1) != '0) || (n_reg == MOVE_W'(MAX_MOVES)));
        sts.emit0    = emit0;
        sts.emit1    = emit1;
        sts.pend1    = emit1_reg;
        sts.dt_zero  = dt_zero_reg;
        sts.div_done = div_done;
        sts.out_free = !out_valid_reg || result.ready;
    end

    a_part_close: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(part_open_reg) |-> $past(cmd.seg_reject || (load && first)))
        else $error("open part closed without a rejected segment or new line");
endmodule

// ===== rtl/core/pcl_ctrl.sv =====
// Controller state machine sequencing load, clip moves, interpolation and word output.
module pcl_ctrl import pcl_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  dp_sts_t   sts,
    output ctrl_cmd_t cmd
);
    ctrl_state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (sts.in_valid && !sts.first)
                begin
                    state_next = ST_TEST;
                end
            end
            ST_TEST:
            begin
                if (sts.accept)
                begin
                    if (sts.emit0)
                    begin
                        state_next = ST_OUT0;
                    end
                    else if (sts.emit1)
                    begin
                        state_next = ST_OUT1;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else if (sts.reject)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                state_next = ST_DIVGO;
            end
            ST_DIVGO:
            begin
                state_next = sts.dt_zero ? ST_WB : ST_DIVWAIT;
            end
            ST_DIVWAIT:
            begin
                if (sts.div_done)
                begin
                    state_next = ST_WB;
                end
            end
            ST_WB:
            begin
                state_next = ST_TEST;
            end
            ST_OUT0:
            begin
                if (sts.out_free)
                begin
                    state_next = sts.pend1 ? ST_OUT1 : ST_IDLE;
                end
            end
            ST_OUT1:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        cmd.take       = (state_reg == ST_IDLE);
        cmd.seg_accept = (state_reg == ST_TEST) && sts.accept;
        cmd.seg_reject = (state_reg == ST_TEST) && !sts.accept && sts.reject;
        cmd.setup      = (state_reg == ST_SETUP);
        cmd.div_start  = (state_reg == ST_DIVGO) && !sts.dt_zero;
        cmd.writeback  = (state_reg == ST_WB);
        cmd.put0       = (state_reg == ST_OUT0) && sts.out_free;
        cmd.put1       = (state_reg == ST_OUT1) && sts.out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_put_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.put0 || cmd.put1) |-> sts.out_free)
        else $error("output word written while the previous one is still held");
endmodule

// ===== rtl/core/polyline_rect_clipper.sv =====
// Top level of the polyline rectangle clipper: clip registers, controller and datapath.
//
// Vertices arrive on the vertex channel (valid/ready); each vertex after the first of a
// line forms a segment with the previous one, clipped against the rectangle held in four
// APB registers (xmin, xmax, ymin, ymax at byte addresses 0, 4, 8, 12 for 32-bit words).
// Visible pieces come out on the result channel, zero to two words per input vertex,
// with last_of_run marking the final word caused by a vertex.
// A vertex is taken only while the controller is idle. Each endpoint move, unless the
// segment runs parallel to the clip edge, uses the shared multiply/divide unit: four
// 32x32 partial products, then 53 quotient bits at one bit a cycle. A segment still
// outside after 16 endpoint moves is rejected.
// The output word sits in a register, so the next vertex is taken while the last word
// still waits; a stalled receiver holds the controller before a further word is written.
// Reset clears the stored vertex and open part and sets the rectangle to the full
// coordinate range; no clearing pass is needed.
module polyline_rect_clipper import pcl_pkg::*; #(
    parameter int  COORD_WIDTH = COORD_WIDTH_DEF,
    localparam int DATA_W      = (COORD_WIDTH > 32) ? 64 : 32,
    localparam int ADDR_LSB    = (COORD_WIDTH > 32) ? 3 : 2,
    localparam int ADDR_W      = ADDR_LSB + REG_IDX_W
) (
    input  logic              clk,
    input  logic              rst_n,
    pcl_vtx_if.sink           vertex,
    pcl_res_if.source         result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);
    localparam int PAD_W = DATA_W - COORD_WIDTH;

    logic signed [COORD_WIDTH-1:0] xmin_reg, xmax_reg, ymin_reg, ymax_reg, rd_val;
    logic [REG_IDX_W-1:0]          reg_idx;
    logic                          wr_en;
    ctrl_cmd_t                     cmd;
    dp_sts_t                       sts;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[ADDR_W-1:ADDR_LSB];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xmin_reg <= {1'b1, {(COORD_WIDTH-1){1'b0}}};
            xmax_reg <= {1'b0, {(COORD_WIDTH-1){1'b1}}};
            ymin_reg <= {1'b1, {(COORD_WIDTH-1){1'b0}}};
            ymax_reg <= {1'b0, {(COORD_WIDTH-1){1'b1}}};
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_XMIN: xmin_reg <= pwdata[COORD_WIDTH-1:0];
                REG_XMAX: xmax_reg <= pwdata[COORD_WIDTH-1:0];
                REG_YMIN: ymin_reg <= pwdata[COORD_WIDTH-1:0];
                REG_YMAX: ymax_reg <= pwdata[COORD_WIDTH-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_XMIN: rd_val = xmin_reg;
            REG_XMAX: rd_val = xmax_reg;
            REG_YMIN: rd_val = ymin_reg;
            REG_YMAX: rd_val = ymax_reg;
            default:  rd_val = '0;
        endcase
        prdata = {{PAD_W{rd_val[COORD_WIDTH-1]}}, rd_val};
    end

    pcl_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    pcl_dpath #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .vertex    (vertex),
        .result    (result),
        .clip_xmin (xmin_reg),
        .clip_xmax (xmax_reg),
        .clip_ymin (ymin_reg),
        .clip_ymax (ymax_reg),
        .cmd       (cmd),
        .sts       (sts)
    );
endmodule

// ===== tb/tb_polyline_rect_clipper.sv =====
// Self-checking testbench of the polyline rectangle clipper: directed table, then random polylines.
module tb_polyline_rect_clipper import pcl_pkg::*;;

    localparam int CW = 32;
    localparam longint CMIN = -(64'sd1 <<< (CW - 1));
    localparam longint CMAX = (64'sd1 <<< (CW - 1)) - 1;
    localparam longint R = 64'sd10 <<< 16;
    localparam int DRAIN_CYCLES = 1200;
    localparam int LONG_HOLD = 3000;
    localparam longint CYCLE_LIMIT = 8000000;
    localparam int N_TYPED = 6;
    localparam int PHASE_ITEMS = 170;

    typedef struct {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic                 sp;
        logic                 last;
    } pt_t;

    typedef struct {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        bit                   sl;
        bit                   typed;
        int                   n;
        logic signed [CW-1:0] ax;
        logic signed [CW-1:0] ay;
        logic signed [CW-1:0] bx;
        logic signed [CW-1:0] by;
    } row_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [3:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    pcl_vtx_if vtx ();
    pcl_res_if res ();

    polyline_rect_clipper dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .vertex  (vtx),
        .result  (res),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    longint xlo = CMIN, xhi = CMAX, ylo = CMIN, yhi = CMAX;
    longint prv_x = 0, prv_y = 0, tl_x = 0, tl_y = 0;
    bit have_prv = 0, part_on = 0;

    pt_t pending_pts[$];
    int errors = 0;
    int words_seen = 0;
    bit calm = 0;
    longint cycles = 0;

    initial
    begin
        clk = 0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("** polyline_rect_clipper: FAILED **");
            $finish;
        end
    end

    function automatic longint unsigned magn(longint v);
        return (v < 0) ? longint'(-v) : v;
    endfunction

    function automatic longint interp(longint at, longint ao, longint bt, longint bo,
                                      longint bound);
        longint dt, num, dob;
        logic [127:0] prod, quo;
        bit neg;
        dt = bt - at;
        num = bound - at;
        dob = bo - ao;
        if (dt == 0)
        begin
            return ao;
        end
        prod = 128'(magn(num)) * 128'(magn(dob));
        quo = prod / 128'(magn(dt));
        if (quo > (128'd1 << QSAT_LOG))
        begin
            quo = 128'd1 << QSAT_LOG;
        end
        neg = ((num < 0) != (dob < 0)) != (dt < 0);
        if (num == 0 || dob == 0)
        begin
            neg = 0;
        end
        return neg ? ao - longint'(quo[63:0]) : ao + longint'(quo[63:0]);
    endfunction

    function automatic ocode_t region(longint x, longint y);
        ocode_t c;
        c = '0;
        if (x < xlo)
        begin
            c |= OC_LEFT;
        end
        else if (x > xhi)
        begin
            c |= OC_RIGHT;
        end
        if (y < ylo)
        begin
            c |= OC_BOTTOM;
        end
        else if (y > yhi)
        begin
            c |= OC_TOP;
        end
        return c;
    endfunction

    function automatic bit clip_segment(inout longint x0, inout longint y0,
                                        inout longint x1, inout longint y1);
        ocode_t c0, c1, co;
        longint nx, ny;
        c0 = region(x0, y0);
        c1 = region(x1, y1);
        for (int n = 0; n <= MAX_MOVES; n++)
        begin
            if ((c0 | c1) == 0)
            begin
                return 1;
            end
            if ((c0 & c1) != 0 || n == MAX_MOVES)
            begin
                return 0;
            end
            co = (c0 != 0) ? c0 : c1;
            if (co & OC_TOP)
            begin
                ny = yhi;
                nx = interp(y0, x0, y1, x1, ny);
            end
            else if (co & OC_BOTTOM)
            begin
                ny = ylo;
                nx = interp(y0, x0, y1, x1, ny);
            end
            else if (co & OC_RIGHT)
            begin
                nx = xhi;
                ny = interp(x0, y0, x1, y1, nx);
            end
            else
            begin
                nx = xlo;
                ny = interp(x0, y0, x1, y1, nx);
            end
            if (co == c0)
            begin
                x0 = nx;
                y0 = ny;
                c0 = region(nx, ny);
            end
            else
            begin
                x1 = nx;
                y1 = ny;
                c1 = region(nx, ny);
            end
        end
        return 0;
    endfunction

    function automatic pt_t mk_pt(longint x, longint y, logic sp);
        pt_t p;
        p.x = x[CW-1:0];
        p.y = y[CW-1:0];
        p.sp = sp;
        p.last = 0;
        return p;
    endfunction

    // Advances the clipper state by one vertex and, when keep is set, queues the words it produces.
    task automatic clip_vertex(longint x, longint y, bit sl, bit keep);
        longint x0, y0, x1, y1;
        pt_t outs[$];
        x0 = prv_x;
        y0 = prv_y;
        x1 = x;
        y1 = y;
        prv_x = x;
        prv_y = y;
        if (sl || !have_prv)
        begin
            have_prv = 1;
            part_on = 0;
            return;
        end
        if (!clip_segment(x0, y0, x1, y1))
        begin
            part_on = 0;
            return;
        end
        if (!part_on || tl_x != x0 || tl_y != y0)
        begin
            outs = {outs, mk_pt(x0, y0, 1)};
            tl_x = x0;
            tl_y = y0;
        end
        if (!part_on || tl_x != x1 || tl_y != y1)
        begin
            outs = {outs, mk_pt(x1, y1, 0)};
            tl_x = x1;
            tl_y = y1;
        end
        part_on = 1;
        if (outs.size() > 0)
        begin
            outs[outs.size() - 1].last = 1;
        end
        if (keep)
        begin
            pending_pts = {pending_pts, outs};
        end
    endtask

    always @(posedge clk)
    begin
        pt_t e;
        if (rst_n && res.valid && res.ready)
        begin
            words_seen <= words_seen + 1;
            if (pending_pts.size() == 0)
            begin
                $error("unexpected word x=%0d y=%0d", res.out_x, res.out_y);
                errors++;
            end
            else
            begin
                e = pending_pts.pop_front();
                if (res.out_x !== e.x)
                begin
                    $error("out_x: expected %0d, got %0d", e.x, res.out_x);
                    errors++;
                end
                if (res.out_y !== e.y)
                begin
                    $error("out_y: expected %0d, got %0d", e.y, res.out_y);
                    errors++;
                end
                if (res.starts_part !== e.sp)
                begin
                    $error("starts_part: expected %0d, got %0d", e.sp, res.starts_part);
                    errors++;
                end
                if (res.last_of_run !== e.last)
                begin
                    $error("last_of_run: expected %0d, got %0d", e.last, res.last_of_run);
                    errors++;
                end
            end
        end
    end

    // Result side: random stalls per word, plus one long hold-off to back up the input.
    initial
    begin
        int stall;
        bit held;
        held = 0;
        res.ready = 0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            stall = calm ? 0 : $urandom_range(0, 15);
            if (!held && words_seen >= 200)
            begin
                held = 1;
                stall = LONG_HOLD;
            end
            if (stall > 0)
            begin
                res.ready <= 0;
                repeat (stall) @(negedge clk);
            end
            res.ready <= 1;
            do
            begin
                @(posedge clk);
            end
            while (!res.valid);
        end
    end

    task automatic send_vertex(longint x, longint y, bit sl, bit keep);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 15);
        @(negedge clk);
        if (gap > 0)
        begin
            vtx.valid <= 0;
            repeat (gap) @(negedge clk);
        end
        vtx.valid <= 1;
        vtx.vertex_x <= x[CW-1:0];
        vtx.vertex_y <= y[CW-1:0];
        vtx.starts_line <= sl;
        do
        begin
            @(posedge clk);
        end
        while (!vtx.ready);
        clip_vertex(x, y, sl, keep);
    endtask

    task automatic drain();
        @(negedge clk);
        vtx.valid <= 0;
        while (pending_pts.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic reg_write(logic [REG_IDX_W-1:0] idx, longint value);
        @(negedge clk);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= {idx, 2'b00};
        pwdata <= value[31:0];
        @(negedge clk);
        penable <= 1;
        @(posedge clk);
        @(negedge clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        case (idx)
            REG_XMIN: xlo = longint'($signed(value[31:0]));
            REG_XMAX: xhi = longint'($signed(value[31:0]));
            REG_YMIN: ylo = longint'($signed(value[31:0]));
            default:  yhi = longint'($signed(value[31:0]));
        endcase
    endtask

    task automatic set_rect(longint x0, longint x1, longint y0, longint y1);
        reg_write(REG_XMIN, x0);
        reg_write(REG_XMAX, x1);
        reg_write(REG_YMIN, y0);
        reg_write(REG_YMAX, y1);
    endtask

    function automatic longint clamp(longint v);
        return (v < CMIN) ? CMIN : (v > CMAX) ? CMAX : v;
    endfunction

    function automatic longint pick_coord(longint lo, longint hi);
        longint span;
        longint unsigned r;
        r = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0: return longint'($signed($urandom));
            1: return $urandom_range(0, 1) ? CMAX : CMIN;
            2: return clamp(($urandom_range(0, 1) ? lo : hi) + $urandom_range(0, 4) - 2);
            default:
            begin
                span = magn(hi - lo) + 65536;
                return clamp(lo - span + longint'(r % longint'(3 * span + 1)));
            end
        endcase
    endfunction

    task automatic random_phase(int items);
        int left;
        bit sl;
        left = 0;
        for (int i = 0; i < items; i++)
        begin
            if (i % 40 == 0)
            begin
                calm = ($urandom_range(0, 3) == 0);
            end
            if (left == 0)
            begin
                sl = 1;
                left = $urandom_range(2, 8);
            end
            else
            begin
                sl = ($urandom_range(0, 19) == 0);
                left--;
            end
            send_vertex(pick_coord(xlo, xhi), pick_coord(ylo, yhi), sl, 1);
        end
        calm = 0;
        drain();
    endtask

    row_t dir_rows[] = '{
        '{0, 0, 0, 1, 0, 0, 0, 0, 0},
        '{CMAX, CMAX, 0, 1, 2, 0, 0, CMAX, CMAX},
        '{CMIN, CMIN, 0, 1, 1, CMIN, CMIN, 0, 0},
        '{CMIN, CMAX, 1, 1, 0, 0, 0, 0, 0},
        '{CMIN, CMAX, 0, 1, 2, CMIN, CMAX, CMIN, CMAX},
        '{CMAX, CMIN, 0, 1, 1, CMAX, CMIN, 0, 0},
        '{-2 * R, 0, 1, 0, 0, 0, 0, 0, 0},
        '{2 * R, 0, 0, 0, 0, 0, 0, 0, 0},
        '{2 * R, 2 * R, 0, 0, 0, 0, 0, 0, 0},
        '{0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{0, 3 * R, 0, 0, 0, 0, 0, 0, 0},
        '{0, -3 * R, 0, 0, 0, 0, 0, 0, 0},
        '{3 * R, -3 * R, 0, 0, 0, 0, 0, 0, 0},
        '{-3 * R, R / 2, 0, 0, 0, 0, 0, 0, 0},
        '{CMIN, CMIN, 0, 0, 0, 0, 0, 0, 0},
        '{CMAX, CMAX, 0, 0, 0, 0, 0, 0, 0},
        '{CMAX, CMIN, 0, 0, 0, 0, 0, 0, 0},
        '{-R, 2 * R, 1, 0, 0, 0, 0, 0, 0},
        '{2 * R, -R + 7, 0, 0, 0, 0, 0, 0, 0},
        '{R, R, 0, 0, 0, 0, 0, 0, 0}
    };

    initial
    begin
        row_t rw;
        pt_t p;
        rst_n = 0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = '0;
        pwdata = '0;
        vtx.valid = 0;
        vtx.vertex_x = '0;
        vtx.vertex_y = '0;
        vtx.starts_line = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        foreach (dir_rows[i])
        begin
            rw = dir_rows[i];
            if (i == N_TYPED)
            begin
                drain();
                set_rect(-R, R, -R, R);
            end
            if (rw.typed)
            begin
                if (rw.n == 2)
                begin
                    p = mk_pt(rw.ax, rw.ay, 1);
                    pending_pts = {pending_pts, p};
                    p = mk_pt(rw.bx, rw.by, 0);
                    p.last = 1;
                    pending_pts = {pending_pts, p};
                end
                else if (rw.n == 1)
                begin
                    p = mk_pt(rw.ax, rw.ay, 0);
                    p.last = 1;
                    pending_pts = {pending_pts, p};
                end
            end
            send_vertex(rw.x, rw.y, rw.sl, !rw.typed);
        end
        drain();

        random_phase(PHASE_ITEMS);
        set_rect(CMIN, CMAX, CMIN, CMAX);
        random_phase(PHASE_ITEMS);
        set_rect(R, -R, 3 * R, R);
        random_phase(PHASE_ITEMS);
        set_rect(R / 3, R / 3, -R, -R);
        random_phase(PHASE_ITEMS);
        set_rect(CMAX, CMIN, CMAX, CMIN);
        random_phase(PHASE_ITEMS);
        set_rect(longint'($signed($urandom)), longint'($signed($urandom)),
                 longint'($signed($urandom)), longint'($signed($urandom)));
        random_phase(PHASE_ITEMS);
        set_rect(-longint'($urandom_range(1, 1 << 22)), longint'($urandom_range(1, 1 << 22)),
                 -longint'($urandom_range(1, 1 << 22)), longint'($urandom_range(1, 1 << 22)));
        random_phase(PHASE_ITEMS);

        if (errors == 0 && pending_pts.size() == 0)
        begin
            $display("** polyline_rect_clipper: PASSED **");
        end
        else
        begin
            $display("** polyline_rect_clipper: FAILED **");
        end
        $finish;
    end

endmodule
